// ----- design/mtab_pkg.sv -----
// shared types, constants and helper functions for the monochrome text adapter
// no dependencies; every other design file imports this package
package mtab_pkg;

    localparam int VRAM_BYTES    = 4096;
    localparam int TEXT_COLUMNS  = 80;
    localparam int VISIBLE_BYTES = 4000;
    localparam int PORT_BYTES    = 16;
    localparam int CRTC_REGS     = 16;

    localparam int VRAM_WORDS = VRAM_BYTES / 2;
    localparam int WORD_AW    = $clog2(VRAM_WORDS);
    localparam int CRTC_AW    = $clog2(CRTC_REGS);

    // visible limit on the byte address {word, lane}
    localparam logic [WORD_AW:0] VIS_LIMIT = (WORD_AW + 1)'(VISIBLE_BYTES);

    // cell index / TEXT_COLUMNS by reciprocal multiplication
    localparam int COL_SHIFT = 24;
    localparam int COL_RECIP = ((2 ** COL_SHIFT) + TEXT_COLUMNS - 1) / TEXT_COLUMNS;

    // bus access kinds
    localparam logic [2:0] KIND_MEM_BYTE    = 3'd0;
    localparam logic [2:0] KIND_MEM_WORD    = 3'd1;
    localparam logic [2:0] KIND_PORT_BYTE_WR = 3'd2;
    localparam logic [2:0] KIND_PORT_WORD_WR = 3'd3;
    localparam logic [2:0] KIND_PORT_BYTE_RD = 3'd4;
    localparam logic [2:0] KIND_PORT_WORD_RD = 3'd5;

    // event codes
    localparam logic [1:0] EV_CELL         = 2'd0;
    localparam logic [1:0] EV_CURSOR_POS   = 2'd1;
    localparam logic [1:0] EV_CURSOR_SHAPE = 2'd2;
    localparam logic [1:0] EV_READ         = 2'd3;

    // port offsets
    localparam logic [11:0] PORT_INDEX  = 12'd0;
    localparam logic [11:0] PORT_DATA   = 12'd1;
    localparam logic [11:0] PORT_MODE   = 12'd4;
    localparam logic [11:0] PORT_STATUS = 12'd6;

    // crtc register numbers
    localparam logic [CRTC_AW-1:0] CRTC_CUR_START = CRTC_AW'(10);
    localparam logic [CRTC_AW-1:0] CRTC_CUR_END   = CRTC_AW'(11);
    localparam logic [CRTC_AW-1:0] CRTC_POS_HI    = CRTC_AW'(14);
    localparam logic [CRTC_AW-1:0] CRTC_POS_LO    = CRTC_AW'(15);

    localparam logic [7:0] SHAPE_LINES   = 8'd13;
    localparam logic [4:0] STATUS_PERIOD = 5'd16;
    localparam logic [7:0] BYTE_NONE     = 8'hff;

    typedef struct packed {
        logic [2:0]  kind;
        logic [11:0] offset;
        logic [15:0] wdata;
    } acc_t;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [6:0]  column;
        logic [9:0]  row;
        logic [15:0] value;
        logic [3:0]  fore_level;
        logic [3:0]  back_level;
        logic [7:0]  shape_top;
        logic [7:0]  shape_bottom;
        logic        last;
    } evt_t;

    typedef enum logic [2:0] {
        UOP_NOP,
        UOP_VBYTE,
        UOP_VWORD,
        UOP_PWR,
        UOP_PRD
    } uop_kind_t;

    // one step of an access: one video byte or word, one port byte write or one port read
    typedef struct packed {
        uop_kind_t          kind;
        logic               is_last;
        logic [WORD_AW-1:0] word;
        logic               lane;
        logic [11:0]        poff;
        logic               pword;
        logic [15:0]        data;
    } uop_t;

    // event before the cell index is split into column and row
    typedef struct packed {
        logic [1:0]  ev;
        logic [15:0] index;
        logic [15:0] value;
        logic [3:0]  fore;
        logic [3:0]  back;
        logic [7:0]  top;
        logic [7:0]  bottom;
    } raw_evt_t;

    typedef struct packed {
        logic     valid;
        logic     emit;
        logic     is_last;
        raw_evt_t evt;
    } evq_push_t;

    typedef struct packed {
        logic [6:0] column;
        logic [9:0] row;
    } cell_pos_t;

    function automatic logic [3:0] level_of_nibble(input logic [3:0] n);
        logic [3:0] lvl;
        if (n[2:0] == 3'd0)
            lvl = 4'h0;
        else if (n[3])
            lvl = 4'hf;
        else
            lvl = 4'h7;
        return lvl;
    endfunction

    // (13 - v) scaled to 0..255, zero past the last line
    function automatic logic [7:0] scale_line(input logic [7:0] v);
        logic [7:0] s;
        case (v)
            8'd0:    s = 8'd255;
            8'd1:    s = 8'd235;
            8'd2:    s = 8'd216;
            8'd3:    s = 8'd196;
            8'd4:    s = 8'd177;
            8'd5:    s = 8'd157;
            8'd6:    s = 8'd137;
            8'd7:    s = 8'd118;
            8'd8:    s = 8'd98;
            8'd9:    s = 8'd78;
            8'd10:   s = 8'd59;
            8'd11:   s = 8'd39;
            8'd12:   s = 8'd20;
            default: s = 8'd0;
        endcase
        return s;
    endfunction

    function automatic cell_pos_t split_index(input logic [15:0] idx);
        logic [39:0] prod;
        logic [15:0] q;
        logic [15:0] rem;
        cell_pos_t   p;
        prod     = 40'(idx) * 40'(COL_RECIP);
        q        = 16'(prod >> COL_SHIFT);
        rem      = idx - 16'(q * 16'(TEXT_COLUMNS));
        p.column = rem[6:0];
        p.row    = q[9:0];
        return p;
    endfunction

endpackage

// ----- design/mtab_vram.sv -----
// video memory: one word per character cell, low byte code, high byte attribute
// one read port with registered data, one write port, zeroing sweep after reset
// depends on mtab_pkg
module mtab_vram (
    input  logic                         clk,
    input  logic                         rst_n,
    output logic                         clr_busy,
    input  logic                         rd_en,
    input  logic [mtab_pkg::WORD_AW-1:0] rd_addr,
    output logic [15:0]                  rd_data,
    input  logic                         wr_en,
    input  logic [mtab_pkg::WORD_AW-1:0] wr_addr,
    input  logic [15:0]                  wr_data
);
    import mtab_pkg::*;

    logic [15:0]        vram_reg [VRAM_WORDS];
    logic [15:0]        rd_data_reg;
    logic               clr_busy_reg;
    logic [WORD_AW-1:0] clr_addr_reg;
    logic               we;
    logic [WORD_AW-1:0] wa;
    logic [15:0]        wd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == WORD_AW'(VRAM_WORDS - 1))
                clr_busy_reg <= 1'b0;
        end
    end

    always_comb
    begin
        we = clr_busy_reg | wr_en;
        wa = clr_busy_reg ? clr_addr_reg : wr_addr;
        wd = clr_busy_reg ? 16'h0000 : wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= vram_reg[rd_addr];
        if (we)
            vram_reg[wa] <= wd;
    end

    assign rd_data  = rd_data_reg;
    assign clr_busy = clr_busy_reg;

endmodule

// ----- design/mtab_front.sv -----
// access register: holds one bus access and splits it into one or two steps
// depends on mtab_pkg
module mtab_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           acc_valid,
    output logic           acc_stall,
    input  mtab_pkg::acc_t acc,
    input  logic           clr_busy,
    input  logic           s1_ready,
    output logic           uop_valid,
    output mtab_pkg::uop_t uop
);
    import mtab_pkg::*;

    logic        s0_valid_reg;
    logic        s0_valid_next;
    acc_t        s0_item_reg;
    logic        phase_reg;
    logic        phase_next;
    logic        two_ops;
    logic        issue;
    logic        take_acc;
    logic [11:0] off_inc;
    uop_t        u;

    always_comb
    begin
        off_inc = s0_item_reg.offset + 12'd1;
        two_ops = 1'b0;
        case (s0_item_reg.kind)
            KIND_MEM_WORD:
                two_ops = s0_item_reg.offset[0]
                          & (s0_item_reg.offset != 12'(VRAM_BYTES - 1));
            KIND_PORT_WORD_WR:
                two_ops = s0_item_reg.offset < 12'(PORT_BYTES - 1);
            default:
                two_ops = 1'b0;
        endcase

        u.kind    = UOP_NOP;
        u.is_last = !two_ops | phase_reg;
        u.word    = s0_item_reg.offset[WORD_AW:1];
        u.lane    = s0_item_reg.offset[0];
        u.poff    = s0_item_reg.offset;
        u.pword   = 1'b0;
        u.data    = {8'h00, s0_item_reg.wdata[7:0]};
        case (s0_item_reg.kind)
            KIND_MEM_BYTE:
                u.kind = UOP_VBYTE;
            KIND_MEM_WORD:
            begin
                if (phase_reg)
                begin
                    // second byte of an odd-address word
                    u.kind = UOP_VBYTE;
                    u.word = off_inc[WORD_AW:1];
                    u.lane = off_inc[0];
                    u.data = {8'h00, s0_item_reg.wdata[15:8]};
                end
                else if (s0_item_reg.offset[0])
                    u.kind = UOP_VBYTE;
                else
                begin
                    u.kind = UOP_VWORD;
                    u.data = s0_item_reg.wdata;
                end
            end
            KIND_PORT_BYTE_WR:
                u.kind = UOP_PWR;
            KIND_PORT_WORD_WR:
            begin
                u.kind = UOP_PWR;
                if (phase_reg)
                begin
                    u.poff = off_inc;
                    u.data = {8'h00, s0_item_reg.wdata[15:8]};
                end
            end
            KIND_PORT_BYTE_RD:
                u.kind = UOP_PRD;
            KIND_PORT_WORD_RD:
            begin
                u.kind  = UOP_PRD;
                u.pword = 1'b1;
            end
            default:
                u.kind = UOP_NOP;
        endcase

        issue     = s0_valid_reg & s1_ready;
        acc_stall = clr_busy | (s0_valid_reg & !(issue & u.is_last));
        take_acc  = acc_valid & !acc_stall;

        s0_valid_next = s0_valid_reg;
        if (take_acc)
            s0_valid_next = 1'b1;
        else if (issue & u.is_last)
            s0_valid_next = 1'b0;

        phase_next = phase_reg;
        if (issue)
            phase_next = !u.is_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            phase_reg    <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= s0_valid_next;
            phase_reg    <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_acc)
            s0_item_reg <= acc;
    end

    assign uop_valid = s0_valid_reg;
    assign uop       = u;

endmodule

// ----- design/mtab_exec.sv -----
// execute stage: video read-compare-write with forwarding, port and crtc registers
// depends on mtab_pkg; drives the ports of mtab_vram and feeds mtab_evq
module mtab_exec (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         uop_valid,
    input  mtab_pkg::uop_t               uop,
    output logic                         s1_ready,
    output logic                         rd_en,
    output logic [mtab_pkg::WORD_AW-1:0] rd_addr,
    input  logic [15:0]                  rd_data,
    output logic                         wr_en,
    output logic [mtab_pkg::WORD_AW-1:0] wr_addr,
    output logic [15:0]                  wr_data,
    output mtab_pkg::evq_push_t          push,
    input  logic                         evq_ok
);
    import mtab_pkg::*;

    logic               s1_valid_reg;
    uop_t               s1_uop_reg;
    logic               fwd_valid_reg;
    logic [WORD_AW-1:0] fwd_addr_reg;
    logic [15:0]        fwd_data_reg;

    logic [7:0]  index_reg;
    logic [7:0]  index_next;
    logic [7:0]  mode_reg;
    logic [7:0]  mode_next;
    logic [7:0]  crtc_bank_reg  [CRTC_REGS];
    logic [7:0]  crtc_bank_next [CRTC_REGS];
    logic [15:0] cursor_reg;
    logic [15:0] cursor_next;
    logic [4:0]  status_reg;
    logic [4:0]  status_next;

    logic               s1_fire;
    logic               take;
    logic [15:0]        cur;
    logic [15:0]        new_word;
    logic [7:0]         old_byte;
    logic               chg;
    logic               is_vram;
    logic [WORD_AW:0]   byte_addr;
    logic               emit;
    raw_evt_t           e;
    logic [7:0]         shp_end;
    logic [7:0]         shp_start;
    logic [15:0]        pos;
    logic [7:0]         creg_sel;
    logic [4:0]         st_inc;
    logic               st_wrap;
    logic               st_hit;
    logic [11:0]        poff_inc;
    logic               hi_ok;
    logic [7:0]         rd_lo;
    logic [7:0]         rd_hi;

    function automatic logic [7:0] port_byte(input logic [11:0] o, input logic [7:0] idx,
                                             input logic [7:0] creg, input logic [7:0] mode,
                                             input logic st);
        logic [7:0] b;
        b = BYTE_NONE;
        if (o < 12'(PORT_BYTES))
        begin
            case (o)
                PORT_INDEX:  b = idx;
                PORT_DATA:   b = (idx < 8'(CRTC_REGS)) ? creg : BYTE_NONE;
                PORT_MODE:   b = mode;
                PORT_STATUS: b = {7'd0, st};
                default:     b = BYTE_NONE;
            endcase
        end
        return b;
    endfunction

    always_comb
    begin
        s1_fire  = s1_valid_reg & evq_ok;
        s1_ready = !s1_valid_reg | s1_fire;
        take     = uop_valid & s1_ready;
        rd_en    = take & (uop.kind inside {UOP_VBYTE, UOP_VWORD});
        rd_addr  = uop.word;

        // the last write always holds the newest data for its word
        cur = (fwd_valid_reg && (fwd_addr_reg == s1_uop_reg.word)) ? fwd_data_reg : rd_data;

        new_word       = cur;
        old_byte       = 8'h00;
        chg            = 1'b0;
        is_vram        = 1'b0;
        byte_addr      = {s1_uop_reg.word, s1_uop_reg.lane};
        emit           = 1'b0;
        e              = '0;
        index_next     = index_reg;
        mode_next      = mode_reg;
        crtc_bank_next = crtc_bank_reg;
        cursor_next    = cursor_reg;
        status_next    = status_reg;
        shp_end        = 8'h00;
        shp_start      = 8'h00;
        pos            = 16'h0000;

        creg_sel = crtc_bank_reg[index_reg[CRTC_AW-1:0]];
        st_inc   = status_reg + 5'd1;
        st_wrap  = st_inc > STATUS_PERIOD;
        poff_inc = s1_uop_reg.poff + 12'd1;
        hi_ok    = s1_uop_reg.pword & (s1_uop_reg.poff < 12'(PORT_BYTES - 1));
        st_hit   = (s1_uop_reg.poff == PORT_STATUS) | (hi_ok & (poff_inc == PORT_STATUS));
        rd_lo    = port_byte(s1_uop_reg.poff, index_reg, creg_sel, mode_reg, st_wrap);
        rd_hi    = hi_ok ? port_byte(poff_inc, index_reg, creg_sel, mode_reg, st_wrap)
                         : 8'h00;

        case (s1_uop_reg.kind)
            UOP_VBYTE:
            begin
                is_vram  = 1'b1;
                old_byte = s1_uop_reg.lane ? cur[15:8] : cur[7:0];
                chg      = old_byte != s1_uop_reg.data[7:0];
                new_word = s1_uop_reg.lane ? {s1_uop_reg.data[7:0], cur[7:0]}
                                           : {cur[15:8], s1_uop_reg.data[7:0]};
            end
            UOP_VWORD:
            begin
                is_vram   = 1'b1;
                byte_addr = {s1_uop_reg.word, 1'b0};
                chg       = cur != s1_uop_reg.data;
                new_word  = s1_uop_reg.data;
            end
            UOP_PWR:
            begin
                case (s1_uop_reg.poff)
                    PORT_INDEX:
                        index_next = s1_uop_reg.data[7:0];
                    PORT_MODE:
                        mode_next = s1_uop_reg.data[7:0];
                    PORT_DATA:
                    begin
                        if (index_reg < 8'(CRTC_REGS))
                        begin
                            crtc_bank_next[index_reg[CRTC_AW-1:0]] = s1_uop_reg.data[7:0];
                            shp_end   = crtc_bank_next[CRTC_CUR_END];
                            shp_start = crtc_bank_next[CRTC_CUR_START];
                            // inverted shape falls back to the full block
                            if (shp_end < shp_start)
                            begin
                                shp_end   = 8'h00;
                                shp_start = SHAPE_LINES;
                            end
                            pos = {crtc_bank_next[CRTC_POS_HI], crtc_bank_next[CRTC_POS_LO]};
                            if (index_reg[CRTC_AW-1:0] == CRTC_CUR_START
                                || index_reg[CRTC_AW-1:0] == CRTC_CUR_END)
                            begin
                                emit     = 1'b1;
                                e.ev     = EV_CURSOR_SHAPE;
                                e.top    = scale_line(shp_end);
                                e.bottom = scale_line(shp_start);
                            end
                            else if ((index_reg[CRTC_AW-1:0] == CRTC_POS_HI
                                      || index_reg[CRTC_AW-1:0] == CRTC_POS_LO)
                                     && pos != cursor_reg)
                            begin
                                emit        = 1'b1;
                                cursor_next = pos;
                                e.ev        = EV_CURSOR_POS;
                                e.index     = pos;
                            end
                        end
                    end
                    default:
                        index_next = index_reg;
                endcase
            end
            UOP_PRD:
            begin
                emit    = 1'b1;
                e.ev    = EV_READ;
                e.value = {rd_hi, rd_lo};
                if (st_hit)
                    status_next = st_wrap ? 5'd0 : st_inc;
            end
            default:
                emit = 1'b0;
        endcase

        if (is_vram)
        begin
            emit    = chg & (byte_addr < VIS_LIMIT);
            e.ev    = EV_CELL;
            e.index = 16'(s1_uop_reg.word);
            e.value = {8'h00, new_word[7:0]};
            e.fore  = level_of_nibble(new_word[11:8]);
            e.back  = level_of_nibble(new_word[15:12]);
        end

        wr_en   = s1_fire & is_vram & chg;
        wr_addr = s1_uop_reg.word;
        wr_data = new_word;

        push.valid   = s1_fire;
        push.emit    = emit;
        push.is_last = s1_uop_reg.is_last;
        push.evt     = e;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            index_reg     <= 8'h00;
            mode_reg      <= 8'h00;
            cursor_reg    <= 16'h0000;
            status_reg    <= 5'd0;
            for (int i = 0; i < CRTC_REGS; i++)
                crtc_bank_reg[i] <= 8'h00;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= take;
            if (wr_en)
                fwd_valid_reg <= 1'b1;
            if (s1_fire)
            begin
                index_reg     <= index_next;
                mode_reg      <= mode_next;
                cursor_reg    <= cursor_next;
                status_reg    <= status_next;
                crtc_bank_reg <= crtc_bank_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            s1_uop_reg <= uop;
        if (wr_en)
        begin
            fwd_addr_reg <= wr_addr;
            fwd_data_reg <= wr_data;
        end
    end

endmodule

// ----- design/mtab_evq.sv -----
// event stage: hold register that settles the last flag, then the output register
// splits the cell index into column and row on the way out; depends on mtab_pkg
module mtab_evq (
    input  logic                clk,
    input  logic                rst_n,
    input  mtab_pkg::evq_push_t push,
    output logic                ok,
    output logic                evt_valid,
    input  logic                evt_stall,
    output mtab_pkg::evt_t      evt
);
    import mtab_pkg::*;

    logic      h_valid_reg;
    logic      h_valid_next;
    logic      h_res_reg;
    logic      h_res_next;
    logic      h_last_reg;
    logic      h_last_next;
    raw_evt_t  h_evt_reg;
    logic      h_load;
    logic      o_valid_reg;
    logic      o_valid_next;
    evt_t      o_evt_reg;
    evt_t      o_evt_next;
    logic      o_free;
    logic      h_unres;
    logic      h_move;
    logic      o_load;
    cell_pos_t pos;

    always_comb
    begin
        o_free  = !o_valid_reg | !evt_stall;
        h_unres = h_valid_reg & !h_res_reg;
        h_move  = h_valid_reg & h_res_reg & o_free;
        // an unsettled event leaves at once when the step after it also emits
        ok      = h_unres ? o_free : (!h_valid_reg | h_move);
        o_load  = h_move | (push.valid & h_unres & push.emit);

        h_valid_next = h_valid_reg;
        h_res_next   = h_res_reg;
        h_last_next  = h_last_reg;
        h_load       = 1'b0;
        if (h_move)
            h_valid_next = 1'b0;
        if (push.valid)
        begin
            if (h_unres && !push.emit)
            begin
                h_res_next  = push.is_last;
                h_last_next = push.is_last;
            end
            else if (push.emit)
            begin
                h_load       = 1'b1;
                h_valid_next = 1'b1;
                h_res_next   = push.is_last;
                h_last_next  = push.is_last;
            end
        end

        o_valid_next = o_valid_reg;
        if (o_load)
            o_valid_next = 1'b1;
        else if (!evt_stall)
            o_valid_next = 1'b0;

        pos                     = split_index(h_evt_reg.index);
        o_evt_next.event_res    = h_evt_reg.ev;
        o_evt_next.column       = pos.column;
        o_evt_next.row          = pos.row;
        o_evt_next.value        = h_evt_reg.value;
        o_evt_next.fore_level   = h_evt_reg.fore;
        o_evt_next.back_level   = h_evt_reg.back;
        o_evt_next.shape_top    = h_evt_reg.top;
        o_evt_next.shape_bottom = h_evt_reg.bottom;
        o_evt_next.last         = h_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_valid_reg <= 1'b0;
            h_res_reg   <= 1'b0;
            h_last_reg  <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            h_valid_reg <= h_valid_next;
            h_res_reg   <= h_res_next;
            h_last_reg  <= h_last_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (h_load)
            h_evt_reg <= push.evt;
        if (o_load)
            o_evt_reg <= o_evt_next;
    end

    assign evt_valid = o_valid_reg;
    assign evt       = o_evt_reg;

endmodule

// ----- design/mono_text_adapter_bus_model_core.sv -----
// top level of the monochrome text adapter: bus accesses in, display events out
// depends on mtab_pkg, mtab_vram, mtab_front, mtab_exec and mtab_evq
//
//   channel  handshake              payload           content
//   acc      acc_valid / acc_stall  mtab_pkg::acc_t   one bus access (kind, offset, wdata)
//   evt      evt_valid / evt_stall  mtab_pkg::evt_t   one display event or read data
//
// an access spends one step in the execute stage per video word or port byte it writes,
// a port read takes one step; a word write at an odd video offset below the last byte
// and a port word write below the last port offset are split into a second step;
// that split comes from the single read-compare-write path into the video RAM
// an event passes the access, execute, hold and output registers; one from the first step
// of a two-step access whose second step emits nothing also waits in the hold register
// after reset a clearing pass zeroes every word of the video RAM, with acc_stall high
// a stalled event waits in the output register, one more waits in the hold register
module mono_text_adapter_bus_model_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           acc_valid,
    output logic           acc_stall,
    input  mtab_pkg::acc_t acc,
    output logic           evt_valid,
    input  logic           evt_stall,
    output mtab_pkg::evt_t evt
);
    import mtab_pkg::*;

    // ram control and the clearing sweep
    logic               clr_busy;
    logic               rd_en;
    logic [WORD_AW-1:0] rd_addr;
    logic [15:0]        rd_data;
    logic               wr_en;
    logic [WORD_AW-1:0] wr_addr;
    logic [15:0]        wr_data;

    // step handoff from the access register to the execute stage
    logic s1_ready;
    logic uop_valid;
    uop_t uop;

    // execute stage to event stage
    evq_push_t push;
    logic      evq_ok;

    mtab_vram u_vram (
        .clk      (clk),
        .rst_n    (rst_n),
        .clr_busy (clr_busy),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data)
    );

    // holds the accepted transfer and splits odd-offset video word and port word writes into two steps
    mtab_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc_valid (acc_valid),
        .acc_stall (acc_stall),
        .acc       (acc),
        .clr_busy  (clr_busy),
        .s1_ready  (s1_ready),
        .uop_valid (uop_valid),
        .uop       (uop)
    );

    // reads the cell word as a step enters, compares and writes back when the step leaves the execute register
    mtab_exec u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .uop_valid (uop_valid),
        .uop       (uop),
        .s1_ready  (s1_ready),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .push      (push),
        .evq_ok    (evq_ok)
    );

    // the last flag of a first-step event is known only after the second step
    mtab_evq u_evq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .ok        (evq_ok),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt)
    );

endmodule
